>>> rtl/tks_pkg.sv
`timescale 1ns / 1ps

package tks_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 8;
  localparam int unsigned KIND_BITS         = 5;
  localparam int unsigned BYTE_BITS         = 8;
  localparam int unsigned NUM_KEYWORDS      = 6;

  localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_IF     = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_EOF    = 5'd16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EOF    = 8'hFF;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_SIGN  = 4'b1000
  } mode_e;

  // keyword order: if else for while break continue
  function automatic logic [3:0] kw_len(input logic [2:0] kw);
    logic [3:0] r;
    unique case (kw)
      3'd0: r = 4'd2;
      3'd1: r = 4'd4;
      3'd2: r = 4'd3;
      3'd3: r = 4'd5;
      3'd4: r = 4'd5;
      3'd5: r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] kw, input logic [2:0] idx);
    logic [63:0] s;
    unique case (kw)
      3'd0: s = {48'h0, "fi"};
      3'd1: s = {32'h0, "esle"};
      3'd2: s = {40'h0, "rof"};
      3'd3: s = {24'h0, "elihw"};
      3'd4: s = {24'h0, "kaerb"};
      3'd5: s = "eunitnoc";
      default: s = 64'h0;
    endcase
    return s[{idx, 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/tks_lexer.sv
`timescale 1ns / 1ps

module tks_lexer import tks_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int unsigned DATA_W        = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic [1:0]        push_cnt_o,
  output logic [DATA_W:0]   tok0_o,
  output logic [DATA_W:0]   tok1_o
);

  localparam int unsigned P = POSITION_BITS;
  localparam int unsigned L = LENGTH_BITS;

  mode_e                mode_q, mode_d;
  logic                 sign_q, sign_d;
  logic [P-1:0]         start_q, start_d;
  logic [L-1:0]         len_q, len_d;
  logic [NUM_KEYWORDS-1:0] cand_q, cand_d;
  logic [P-1:0]         pos_q, pos_d;

  logic is_digit, is_alpha, is_space, is_word;
  logic [NUM_KEYWORDS-1:0] match_cont, match_fresh;
  logic [L-1:0]         len_grow;
  logic                 flush_v;
  logic [KIND_BITS-1:0] flush_kind, ident_kind, char_kind;
  logic [L-1:0]         flush_len;
  logic                 a_v, b_v, char_known;
  logic [DATA_W-1:0]    a_data, b_data;

  always_comb begin
    is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    is_alpha = ((byte_i >= CH_LO_A) && (byte_i <= CH_LO_Z)) ||
               ((byte_i >= CH_UP_A) && (byte_i <= CH_UP_Z));
    is_space = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
    is_word  = is_alpha || (byte_i == CH_UNDER);
    len_grow = (len_q == '1) ? len_q : len_q + 1'b1;
  end

  always_comb begin
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      match_cont[i]  = cand_q[i] && (len_q < L'(kw_len(3'(i)))) &&
                       (kw_char(3'(i), len_q[2:0]) == byte_i);
      match_fresh[i] = (kw_char(3'(i), 3'd0) == byte_i);
    end
  end

  always_comb begin
    ident_kind = KIND_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (cand_q[i] && (len_q == L'(kw_len(3'(i))))) begin
        ident_kind = 5'(KIND_IF + 5'(i));
      end
    end
  end

  always_comb begin
    flush_v    = 1'b1;
    flush_kind = KIND_NUMBER;
    flush_len  = len_q;
    unique case (mode_q)
      MODE_NUM:   flush_kind = KIND_NUMBER;
      MODE_IDENT: flush_kind = ident_kind;
      MODE_SIGN: begin
        flush_kind = sign_q ? KIND_MINUS : KIND_PLUS;
        flush_len  = L'(1);
      end
      default:    flush_v = 1'b0;
    endcase
  end

  always_comb begin
    char_known = 1'b1;
    char_kind  = KIND_EOF;
    unique case (byte_i)
      CH_STAR:   char_kind = KIND_STAR;
      CH_SLASH:  char_kind = KIND_SLASH;
      CH_SEMI:   char_kind = KIND_SEMI;
      CH_ASSIGN: char_kind = KIND_ASSIGN;
      CH_LBRACE: char_kind = KIND_LBRACE;
      CH_RBRACE: char_kind = KIND_RBRACE;
      CH_EOF:    char_kind = KIND_EOF;
      default:   char_known = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    sign_d  = sign_q;
    start_d = start_q;
    len_d   = len_q;
    cand_d  = cand_q;
    pos_d   = pos_q;
    a_v     = 1'b0;
    b_v     = 1'b0;
    if (step_i) begin
      pos_d = pos_q + 1'b1;
      if (byte_i == CH_NUL) begin
        a_v     = flush_v;
        mode_d  = MODE_IDLE;
        sign_d  = 1'b0;
        start_d = '0;
        len_d   = '0;
        cand_d  = '1;
        pos_d   = '0;
      end else if ((mode_q == MODE_NUM) && is_digit) begin
        len_d = len_grow;
      end else if ((mode_q == MODE_IDENT) && (is_word || is_digit)) begin
        cand_d = match_cont;
        len_d  = len_grow;
      end else if ((mode_q == MODE_SIGN) && is_digit) begin
        mode_d = MODE_NUM;
        len_d  = len_grow;
      end else begin
        a_v    = flush_v;
        mode_d = MODE_IDLE;
        len_d  = '0;
        cand_d = '1;
        if (is_space) begin
          mode_d = MODE_IDLE;
        end else if (is_digit) begin
          mode_d  = MODE_NUM;
          start_d = pos_q;
          len_d   = L'(1);
        end else if (is_word) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
          len_d   = L'(1);
          cand_d  = match_fresh;
        end else if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
          mode_d  = MODE_SIGN;
          sign_d  = (byte_i == CH_MINUS);
          start_d = pos_q;
          len_d   = L'(1);
        end else begin
          b_v = char_known;
        end
      end
    end
  end

  always_comb begin
    a_data = '0;
    a_data[KIND_BITS-1:0]       = flush_kind;
    a_data[KIND_BITS +: P]      = start_q;
    a_data[KIND_BITS + P +: L]  = flush_len;
    b_data = '0;
    b_data[KIND_BITS-1:0]       = char_kind;
    b_data[KIND_BITS +: P]      = pos_q;
    b_data[KIND_BITS + P +: L]  = L'(1);
  end

  // first token ends the run only when it is alone
  assign push_cnt_o = {1'b0, a_v} + {1'b0, b_v};
  assign tok0_o     = a_v ? {!b_v, a_data} : {1'b1, b_data};
  assign tok1_o     = {1'b1, b_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      sign_q  <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      cand_q  <= '1;
      pos_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      sign_q  <= sign_d;
      start_q <= start_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
      pos_q   <= pos_d;
    end
  end

endmodule

>>> rtl/tks_out_fifo.sv
`timescale 1ns / 1ps

module tks_out_fifo import tks_pkg::*; #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] d0_i,
  input  logic [WIDTH-1:0] d1_i,
  output logic             room2_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [4];
  logic [1:0]       wr_q, rd_q;
  logic [2:0]       count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  assign room2_o = (count_q - {2'b00, pop}) <= 3'd2;
  assign count_d = count_q + {1'b0, push_cnt_i} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= d0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + 2'd1] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_cnt_i;
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/token_scanner.sv
`timescale 1ns / 1ps

// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata: text_byte
// m_axis   out  m_axis_tvalid/tready       tdata: kind, start, length; tlast: last_of_run
//
// one byte accepted per cycle while input is not stalled; a byte is registered in byte_q before it reaches the lexer
// each byte yields zero, one or two tokens, pushed at once into a four-entry queue
// the output drains one token per cycle while m_axis_tready is high, so bytes giving two tokens can slow intake
// input stalls only while the queue cannot take two more tokens
// reset clears the scan state, position and queue; no clearing pass

module token_scanner import tks_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF,
  localparam int unsigned DATA_W = ((KIND_BITS + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,  // text_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // token_kind, token_start, token_length, zero fill
  output logic [DATA_W-1:0] m_axis_tdata_o,
  output logic              m_axis_tlast_o   // last_of_run
);

  logic        vld_q, vld_d;
  logic [7:0]  byte_q;
  logic        room2, advance, accept;
  logic [1:0]  push_cnt;
  logic [DATA_W:0] tok0, tok1;

  assign advance         = vld_q && room2;
  assign s_axis_tready_o = !vld_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign vld_d           = accept ? 1'b1 : (advance ? 1'b0 : vld_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  tks_lexer #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .DATA_W        (DATA_W)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (byte_q),
    .push_cnt_o (push_cnt),
    .tok0_o     (tok0),
    .tok1_o     (tok1)
  );

  tks_out_fifo #(
    .WIDTH (DATA_W + 1)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .d0_i       (tok0),
    .d1_i       (tok1),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .data_o     ({m_axis_tlast_o, m_axis_tdata_o})
  );

`ifndef SYNTHESIS
  a_no_triple_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt != 2'd3)
    else $error("lexer pushed more than two tokens");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd2) |-> (!tok0[DATA_W] && tok1[DATA_W]))
    else $error("token pair with wrong run end marks");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !room2) |=> (vld_q && $stable(byte_q)))
    else $error("stalled input byte lost");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (push_cnt == 2'd0))
    else $error("token pushed without a byte");
`endif

endmodule
